// ===== rtl/core/arsw_pkg.sv =====
// Shared widths, command codes and the bit-count helper of the anti-replay window.
package arsw_pkg;

  localparam int unsigned SeqW = 48;
  localparam int unsigned CntW = 32;
  localparam int unsigned WinW = 7;
  localparam int unsigned MapMaxW = 64;

  localparam logic OpCheck = 1'b0;
  localparam logic OpClear = 1'b1;

  // Counts the set bits per byte first, then adds the eight byte counts.
  function automatic logic [WinW-1:0] popcount64(input logic [MapMaxW-1:0] v);
    logic [3:0] byte_cnt [8];
    logic [WinW-1:0] total;
    for (int b = 0; b < 8; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + {3'b000, v[b*8+i]};
      end
    end
    total = '0;
    for (int b = 0; b < 8; b++) begin
      total = total + {3'b000, byte_cnt[b]};
    end
    return total;
  endfunction

endpackage

// ===== rtl/core/arsw_ram.sv =====
// Generic synchronous RAM with separate write and read addresses and a registered, read-first read.
module arsw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/anti_replay_sliding_window.sv =====
// Top level of the anti-replay sliding window checker.
// Checks 48-bit record sequence numbers against a sliding bitmap window and
// accepts one beat per clock cycle while the output is not stalled; each
// beat passes through stage one into the output register, where its result
// beat is held while the output is stalled. The highest number,
// the window bitmap and the saturating replay counter live in one word of a
// synchronous RAM that is read every cycle; the word written at the previous
// edge is forwarded, so consecutive beats see each other's updates. A write to
// the window size register clamps the value to min(MaxWindow, 64), ignores
// zero, and spends the following cycle writing the word back with the bitmap
// trimmed to the new size. A clear command empties the window and the highest
// number but keeps the replay counter.
module anti_replay_sliding_window #(
  parameter int unsigned MaxWindow = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [arsw_pkg::WinW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [arsw_pkg::SeqW-1:0]  sequence_number_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       replay_flag_o,
  output logic [arsw_pkg::SeqW-1:0]  highest_seen_o,
  output logic [arsw_pkg::CntW-1:0]  replays_total_o,
  output logic [arsw_pkg::WinW-1:0]  slots_used_o
);

  localparam int unsigned SeqW = arsw_pkg::SeqW;
  localparam int unsigned CntW = arsw_pkg::CntW;
  localparam int unsigned WinW = arsw_pkg::WinW;
  localparam int unsigned MapW = (MaxWindow < arsw_pkg::MapMaxW) ? MaxWindow
                                                                 : arsw_pkg::MapMaxW;
  localparam int unsigned ShW = (MapW > 1) ? $clog2(MapW) : 1;
  localparam int unsigned WordW = CntW + SeqW + MapW;
  localparam logic [WinW-1:0] WinLimit = WinW'(MapW);

  // Window size register and the pending trim of the stored bitmap.
  logic [WinW-1:0] window_q, window_d;
  logic            trim_q;

  always_comb begin
    window_d = window_q;
    if (cfg_we_i && (cfg_wdata_i != '0)) begin
      window_d = (cfg_wdata_i > WinLimit) ? WinLimit : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinLimit;
      trim_q   <= 1'b0;
    end else begin
      window_q <= window_d;
      trim_q   <= cfg_we_i;
    end
  end

  // Stage one holds the beat while the state word is read.
  logic            s1_valid_q;
  logic            s1_op_q;
  logic [SeqW-1:0] s1_seq_q;
  logic            out_valid_q;
  logic            s1_adv;
  logic            in_accept;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= opcode_i;
      s1_seq_q <= sequence_number_i;
    end
  end

  // State word storage with forwarding of the word written at the last edge.
  logic             ram_we;
  logic [WordW-1:0] ram_wdata;
  logic [WordW-1:0] ram_rdata;
  logic [WordW-1:0] fwd_q;
  logic             fwd_valid_q;
  logic             init_q;
  logic [WordW-1:0] cur_word;

  arsw_ram #(
    .Width (WordW),
    .Depth (1)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (1'b0),
    .wdata_i (ram_wdata),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (fwd_valid_q) begin
      cur_word = fwd_q;
    end else if (init_q) begin
      cur_word = ram_rdata;
    end else begin
      cur_word = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      init_q      <= 1'b0;
    end else begin
      fwd_valid_q <= ram_we;
      if (ram_we) begin
        init_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_q <= ram_wdata;
    end
  end

  // Check and update of the window.
  logic [MapW-1:0] wmask;
  logic [MapW-1:0] cur_map;
  logic [SeqW-1:0] cur_high;
  logic [CntW-1:0] cur_cnt;
  logic [SeqW:0]   diff_hs;
  logic [SeqW-1:0] gap;
  logic [SeqW-1:0] pos;
  logic [SeqW-1:0] win_ext;
  logic            newer;
  logic            too_old;
  logic [MapW-1:0] bit_sel;
  logic            hit;
  logic [MapW-1:0] new_map;
  logic [SeqW-1:0] new_high;
  logic [CntW-1:0] new_cnt;
  logic            replay;
  logic            commit;

  always_comb begin
    for (int i = 0; i < MapW; i++) begin
      wmask[i] = (WinW'(i) < window_q);
    end
  end

  assign cur_map  = cur_word[MapW-1:0] & wmask;
  assign cur_high = cur_word[MapW +: SeqW];
  assign cur_cnt  = cur_word[MapW+SeqW +: CntW];

  assign diff_hs = {1'b0, cur_high} - {1'b0, s1_seq_q};
  assign newer   = diff_hs[SeqW];
  assign pos     = diff_hs[SeqW-1:0];
  assign gap     = s1_seq_q - cur_high;
  assign win_ext = {{(SeqW-WinW){1'b0}}, window_q};
  assign too_old = !newer && (pos >= win_ext);
  assign bit_sel = cur_map >> pos[ShW-1:0];
  assign hit     = bit_sel[0];

  always_comb begin
    new_map  = cur_map;
    new_high = cur_high;
    replay   = 1'b0;
    if (s1_op_q == arsw_pkg::OpClear) begin
      new_map  = '0;
      new_high = '0;
    end else if (too_old) begin
      replay = 1'b1;
    end else if (newer) begin
      if (gap >= win_ext) begin
        new_map = {{(MapW-1){1'b0}}, 1'b1};
      end else begin
        new_map = (cur_map << gap[ShW-1:0]) | {{(MapW-1){1'b0}}, 1'b1};
      end
      new_high = s1_seq_q;
    end else if (hit) begin
      replay = 1'b1;
    end else begin
      new_map = cur_map | ({{(MapW-1){1'b0}}, 1'b1} << pos[ShW-1:0]);
    end
    new_map = new_map & wmask;
    new_cnt = cur_cnt;
    if (replay && (cur_cnt != '1)) begin
      new_cnt = cur_cnt + CntW'(1);
    end
  end

  assign commit = s1_valid_q && s1_adv;
  assign ram_we = commit || trim_q;

  always_comb begin
    if (commit) begin
      ram_wdata = {new_cnt, new_high, new_map};
    end else begin
      ram_wdata = {cur_cnt, cur_high, cur_map};
    end
  end

  // Output register.
  logic            out_replay_q;
  logic [SeqW-1:0] out_high_q;
  logic [CntW-1:0] out_cnt_q;
  logic [MapW-1:0] out_map_q;
  logic [arsw_pkg::MapMaxW-1:0] out_map_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_replay_q <= replay;
      out_high_q   <= new_high;
      out_cnt_q    <= new_cnt;
      out_map_q    <= new_map;
    end
  end

  always_comb begin
    out_map_ext = '0;
    out_map_ext[MapW-1:0] = out_map_q;
  end

  assign out_valid_o     = out_valid_q;
  assign replay_flag_o   = out_replay_q;
  assign highest_seen_o  = out_high_q;
  assign replays_total_o = out_cnt_q;
  assign slots_used_o    = arsw_pkg::popcount64(out_map_ext);

endmodule

// ===== verif/anti_replay_sliding_window_tb.sv =====
// Self-checking testbench for the anti-replay sliding window checker.
`timescale 1ns / 1ps

module anti_replay_sliding_window_tb;

  localparam int unsigned SeqW = arsw_pkg::SeqW;
  localparam int unsigned CntW = arsw_pkg::CntW;
  localparam int unsigned WinW = arsw_pkg::WinW;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned MapBits = 64;

  typedef struct packed {
    logic            replay;
    logic [SeqW-1:0] highest;
    logic [CntW-1:0] total;
    logic [WinW-1:0] used;
  } verdict_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [WinW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            opcode_i = arsw_pkg::OpCheck;
  logic [SeqW-1:0] sequence_number_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            replay_flag_o;
  logic [SeqW-1:0] highest_seen_o;
  logic [CntW-1:0] replays_total_o;
  logic [WinW-1:0] slots_used_o;

  anti_replay_sliding_window dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .sequence_number_i (sequence_number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .replay_flag_o     (replay_flag_o),
    .highest_seen_o    (highest_seen_o),
    .replays_total_o   (replays_total_o),
    .slots_used_o      (slots_used_o)
  );

  // Predictor state, mirroring the window held inside the block.
  int unsigned        window_len = 64;
  logic [SeqW-1:0]    top_seq = '0;
  logic [MapBits-1:0] seen_map = '0;
  logic [CntW-1:0]    replay_cnt = '0;

  verdict_t pending_verdicts[$];

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned replays_seen = 0;
  int unsigned clears_sent = 0;
  int unsigned window_writes = 0;
  bit          calm = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_issued = 0;
  int unsigned hold_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [MapBits-1:0] window_mask(input int unsigned len);
    if (len >= MapBits) begin
      return '1;
    end
    return (64'd1 << len) - 64'd1;
  endfunction

  // Works out the result of one accepted beat and advances the predicted window.
  function automatic verdict_t judge_record(input logic op, input logic [SeqW-1:0] seq);
    verdict_t           v;
    logic [MapBits-1:0] mask;
    logic [63:0]        gap;
    logic [63:0]        pos;
    logic               flag;
    mask = window_mask(window_len);
    flag = 1'b0;
    if (op == arsw_pkg::OpClear) begin
      top_seq  = '0;
      seen_map = '0;
    end else if ({16'd0, seq} + 64'(window_len) <= {16'd0, top_seq}) begin
      flag = 1'b1;
    end else if (seq > top_seq) begin
      gap = {16'd0, seq} - {16'd0, top_seq};
      if (gap >= 64'(window_len)) begin
        seen_map = '0;
      end else begin
        seen_map = (seen_map << gap) & mask;
      end
      seen_map[0] = 1'b1;
      top_seq = seq;
    end else begin
      pos = {16'd0, top_seq} - {16'd0, seq};
      if (seen_map[pos[5:0]]) begin
        flag = 1'b1;
      end else begin
        seen_map[pos[5:0]] = 1'b1;
      end
    end
    seen_map = seen_map & mask;
    if (flag && replay_cnt != '1) begin
      replay_cnt = replay_cnt + 1'b1;
    end
    v.replay  = flag;
    v.highest = top_seq;
    v.total   = replay_cnt;
    v.used    = WinW'($countones(seen_map));
    return v;
  endfunction

  // Offers one beat, with a random gap first unless the sender is running calm.
  task automatic send_record(input logic op, input logic [SeqW-1:0] seq);
    verdict_t verdict;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    sequence_number_i <= seq;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    verdict = judge_record(op, seq);
    pending_verdicts = {pending_verdicts, verdict};
    beats_sent++;
    if (op == arsw_pkg::OpClear) begin
      clears_sent++;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_window(input logic [WinW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_writes++;
    // Zero is ignored; anything past the bitmap width saturates to it.
    if (value != '0) begin
      window_len = (value > MapBits) ? MapBits : value;
      seen_map   = seen_map & window_mask(window_len);
    end
  endtask

  // Mostly numbers near the current highest, so the bitmap is really exercised.
  task automatic send_random_record();
    int unsigned     pick;
    logic [SeqW-1:0] seq;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_record(arsw_pkg::OpClear, SeqW'({$urandom, $urandom}));
    end else begin
      if (pick < 8) begin
        seq = SeqW'({$urandom, $urandom});
      end else if (pick < 55) begin
        seq = top_seq + $urandom_range(window_len + 2, 1);
      end else if (pick < 90) begin
        seq = top_seq - $urandom_range(window_len - 1, 0);
      end else begin
        seq = top_seq - $urandom_range(window_len + 100, window_len);
      end
      send_record(arsw_pkg::OpCheck, seq);
    end
  endtask

  task automatic test_default_window();
    logic [SeqW-1:0] top;
    top = '1;
    send_record(arsw_pkg::OpCheck, 48'd0);
    send_record(arsw_pkg::OpCheck, 48'd0);
    send_record(arsw_pkg::OpCheck, 48'd5);
    send_record(arsw_pkg::OpCheck, 48'd3);
    send_record(arsw_pkg::OpCheck, 48'd3);
    send_record(arsw_pkg::OpCheck, 48'd69);
    send_record(arsw_pkg::OpCheck, 48'd5);
    send_record(arsw_pkg::OpCheck, 48'd6);
    send_record(arsw_pkg::OpCheck, top);
    send_record(arsw_pkg::OpCheck, top - 48'd63);
    send_record(arsw_pkg::OpCheck, top - 48'd64);
    send_record(arsw_pkg::OpCheck, top - 48'd1);
    send_record(arsw_pkg::OpClear, top);
    send_record(arsw_pkg::OpCheck, 48'd0);
    send_record(arsw_pkg::OpCheck, 48'd1);
    drain_results();
  endtask

  task automatic test_window_extremes();
    set_window('0);
    send_record(arsw_pkg::OpCheck, 48'd200);
    send_record(arsw_pkg::OpCheck, 48'd137);
    set_window(7'd1);
    send_record(arsw_pkg::OpCheck, 48'd210);
    send_record(arsw_pkg::OpCheck, 48'd210);
    send_record(arsw_pkg::OpCheck, 48'd209);
    send_record(arsw_pkg::OpCheck, 48'd211);
    send_record(arsw_pkg::OpClear, 48'd0);
    send_record(arsw_pkg::OpCheck, 48'd0);
    set_window('1);
    send_record(arsw_pkg::OpCheck, 48'd63);
    send_record(arsw_pkg::OpCheck, 48'd0);
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [WinW-1:0] sizes[6];
    sizes[0] = 7'd17;
    sizes[1] = WinW'($urandom_range(127, 65));
    sizes[2] = 7'd3;
    sizes[3] = 7'd64;
    sizes[4] = WinW'($urandom_range(64, 1));
    sizes[5] = 7'd1;
    foreach (sizes[i]) begin
      set_window(sizes[i]);
      repeat (90) send_random_record();
      drain_results();
    end
  endtask

  task automatic test_no_idle_stretch();
    set_window(7'd32);
    calm = 1'b1;
    repeat (40) send_random_record();
    drain_results();
    calm = 1'b0;
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    hold_requests++;
    calm = 1'b1;
    repeat (30) send_random_record();
    drain_results();
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_issued != hold_requests) begin
      hold_issued = hold_requests;
      hold_left   = HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 28);
    end
  end

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (mismatches < 10) begin
      $display("%0t: %s differs, expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        note_mismatch("unexpected result beat, highest_seen", 64'd0, 64'(highest_seen_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (want.replay) begin
          replays_seen++;
        end
        if (replay_flag_o !== want.replay) begin
          note_mismatch("replay flag", 64'(want.replay), 64'(replay_flag_o));
        end
        if (highest_seen_o !== want.highest) begin
          note_mismatch("highest_seen", 64'(want.highest), 64'(highest_seen_o));
        end
        if (replays_total_o !== want.total) begin
          note_mismatch("replays_total", 64'(want.total), 64'(replays_total_o));
        end
        if (slots_used_o !== want.used) begin
          note_mismatch("slots_used", 64'(want.used), 64'(slots_used_o));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_window_extremes();
    test_random_phases();
    test_no_idle_stretch();
    test_backpressure();
    drain_results();
    repeat (6) @(posedge clk_i);
    mismatches += pending_verdicts.size();
    $display("Checked %0d result beats for %0d input beats, %0d of them replays.",
             results_seen, beats_sent, replays_seen);
    $display("Covered %0d window size writes, %0d clear commands and one long output hold.",
             window_writes, clears_sent);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
